/* rtl/core/boe_pkg.sv */
package boe_pkg;

	// position fields as carried on the result channel
	localparam int POS_W = 10;

	// a single pixel causes up to this many result beats
	localparam int MAX_RES = 3;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// register indexes on the write port
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// one result beat
	typedef struct packed {
		logic             is_outline;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} result_t;

	// results of one pixel, packed from slot 0 upward
	typedef struct packed {
		logic [1:0]            num;
		result_t [MAX_RES-1:0] res;
	} res_set_t;

endpackage

/* rtl/core/boe_ram.sv */
module boe_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

/* rtl/core/boe_window.sv */
module boe_window #(
	parameter int COL_W = 10,
	parameter int ROW_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [COL_W:0]      w,
	input  logic [ROW_W:0]      h,
	input  logic                top,
	input  logic                mid,
	input  logic                fg,
	output boe_pkg::res_set_t   res_set
);

	logic [5:0]        window_q;
	logic [2:0]        col_now;
	logic [ROW_W-1:0]  rm1;
	logic [COL_W-1:0]  cm1;
	logic              pa, pb, pc;
	logic              flag_a;
	boe_pkg::result_t  ra, rb, rc;

	assign col_now = {top, mid, fg};
	assign rm1     = row - ROW_W'(1);
	assign cm1     = col - COL_W'(1);

	always_comb begin
		pa = (row != '0) && (col != '0);
		pb = (row != '0) && ({1'b0, col} == w - (COL_W+1)'(1));
		pc = ({1'b0, row} == h - (ROW_W+1)'(1));

		// upper-left neighbour of the current pixel is now fully surrounded
		if (!window_q[1]) begin
			flag_a = 1'b0;
		end else if (rm1 == '0 || cm1 == '0 || {1'b0, cm1} == w - (COL_W+1)'(1)) begin
			flag_a = 1'b1;
		end else begin
			flag_a = !(window_q == 6'h3F && col_now == 3'h7);
		end

		ra.is_outline = flag_a;
		ra.row        = boe_pkg::POS_W'(rm1);
		ra.col        = boe_pkg::POS_W'(cm1);
		ra.last       = !pb && !pc;

		// pixel above, last column
		rb.is_outline = mid;
		rb.row        = boe_pkg::POS_W'(rm1);
		rb.col        = boe_pkg::POS_W'(col);
		rb.last       = !pc;

		// last row, decided from itself
		rc.is_outline = fg;
		rc.row        = boe_pkg::POS_W'(row);
		rc.col        = boe_pkg::POS_W'(col);
		rc.last       = 1'b1;

		res_set.num    = {1'b0, pa} + {1'b0, pb} + {1'b0, pc};
		res_set.res[0] = pa ? ra : (pb ? rb : rc);
		res_set.res[1] = pa ? (pb ? rb : rc) : rc;
		res_set.res[2] = rc;
		if (!step) begin
			res_set.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (step) begin
			window_q <= {window_q[2:0], col_now};
		end
	end

endmodule

/* rtl/core/boe_rfifo.sv */
module boe_rfifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  boe_pkg::res_set_t             push,
	input  logic                          pop,
	output boe_pkg::result_t              head,
	output logic [boe_pkg::FIFO_CW-1:0]   count
);

	boe_pkg::result_t                 mem_q [boe_pkg::FIFO_DEPTH];
	logic [boe_pkg::FIFO_AW-1:0]      wr_q;
	logic [boe_pkg::FIFO_AW-1:0]      rd_q;
	logic [boe_pkg::FIFO_CW-1:0]      cnt_q;

	assign head  = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < boe_pkg::MAX_RES; i++) begin
			if (2'(i) < push.num) begin
				mem_q[wr_q + boe_pkg::FIFO_AW'(i)] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + boe_pkg::FIFO_AW'(push.num);
			rd_q  <= rd_q + boe_pkg::FIFO_AW'(pop);
			cnt_q <= cnt_q + boe_pkg::FIFO_CW'(push.num) - boe_pkg::FIFO_CW'(pop);
		end
	end

endmodule

/* rtl/core/binary_outline_extract.sv */
// binary outline extraction, 3x3 window
// pixels enter on the input channel (in_valid / in_stall / pixel_value) in
// raster order, one beat per pixel; a value of 0 is foreground. every decided
// pixel leaves as one beat on the output channel (out_valid / out_stall) with
// its flag, row, column and last_of_run on the final beat caused by one pixel.
// a pixel causes 0 to 3 beats: interior pixels are decided once their
// lower-right neighbour arrives, the last column and last row add their own.
// frame size comes from the write port (cfg_we, cfg_index 0 = width,
// 1 = height); write it only while the block is idle.
//
// throughput: one pixel per clock, limited by the output channel at one beat
// per clock; the line store is a single 2-bit wide memory read as a pixel is
// accepted and written back from stage 1, with a bypass for one-pixel rows.
// a pixel's beats pass the stage 1 registers and the result queue before output.
// an 8-entry result queue decouples the sides: input stalls only when the
// queue cannot take the worst case of the pixels already in flight, so a
// stalled receiver stops input after a few beats and loses nothing.
// reset: position returns to row 0 column 0, size to 1024 x 1024, the queue
// and window empty; line store content is not cleared and is unused until
// written by the first rows of a frame.
module binary_outline_extract #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [10:0]                 cfg_data,
	// pixel input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  pixel_value,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_outline,
	output logic [boe_pkg::POS_W-1:0]   out_row,
	output logic [boe_pkg::POS_W-1:0]   out_col,
	output logic                        last_of_run
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// size registers, raw as written
	logic [10:0]   width_q;
	logic [10:0]   height_q;
	// clamped sizes
	logic [CW:0]   w;
	logic [RW:0]   h;

	// position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// position of the pixel being accepted, and the one after it
	logic          col_wrap;
	logic [RW:0]   r_inc;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [CW:0]   c_nx;
	logic [RW:0]   r_nx;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;

	logic          accept;
	logic          pop;

	// stage 1: line store data available, decision made
	logic          s1_valid;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          fg_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;

	logic [1:0]    ram_rdata;
	logic [1:0]    line_s1;

	boe_pkg::res_set_t              res_set;
	boe_pkg::result_t               head;
	logic [boe_pkg::FIFO_CW-1:0]    fifo_cnt;

	// size clamping: 0 acts as 1, beyond the maximum acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			w = (CW+1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w = (CW+1)'(MAX_WIDTH);
		end else begin
			w = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			h = (RW+1)'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h = (RW+1)'(MAX_HEIGHT);
		end else begin
			h = (RW+1)'(height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				boe_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				boe_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default:             width_q  <= width_q;
			endcase
		end
	end

	// position bookkeeping; a shrunk size wraps the stored position first
	always_comb begin
		col_wrap = ({1'b0, col_q} >= w);
		c0       = col_wrap ? '0 : col_q;
		r_inc    = {1'b0, row_q} + (RW+1)'(col_wrap);
		r0       = (r_inc >= h) ? '0 : r_inc[RW-1:0];
		c_nx     = {1'b0, c0} + (CW+1)'(1);
		r_nx     = {1'b0, r0} + (RW+1)'(1);
		if (c_nx >= w) begin
			col_d = '0;
			row_d = (r_nx >= h) ? '0 : r_nx[RW-1:0];
		end else begin
			col_d = c_nx[CW-1:0];
			row_d = r0;
		end
	end

	// room for the worst case of the pixel in stage 1 plus the new one
	assign in_stall = ({1'b0, fifo_cnt} + (s1_valid ? (boe_pkg::FIFO_CW+1)'(boe_pkg::MAX_RES)
	                                                : '0))
	                  > (boe_pkg::FIFO_CW+1)'(boe_pkg::FIFO_DEPTH - boe_pkg::MAX_RES);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
		end
	end

	// stage 1 payload; bypass when stage 1 writes the column being read
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= c0;
			row_s1      <= r0;
			fg_s1       <= (pixel_value == 8'd0);
			fwd_s1      <= s1_valid && (col_s1 == c0);
			fwd_data_s1 <= {line_s1[0], fg_s1};
		end
	end

	// bit 1: two rows up, bit 0: one row up
	boe_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (col_s1),
		.wdata ({line_s1[0], fg_s1}),
		.raddr (c0),
		.rdata (ram_rdata)
	);

	assign line_s1 = fwd_s1 ? fwd_data_s1 : ram_rdata;

	boe_window #(
		.COL_W (CW),
		.ROW_W (RW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_valid),
		.row     (row_s1),
		.col     (col_s1),
		.w       (w),
		.h       (h),
		.top     (line_s1[1]),
		.mid     (line_s1[0]),
		.fg      (fg_s1),
		.res_set (res_set)
	);

	assign pop = out_valid && !out_stall;

	boe_rfifo u_rfifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_set),
		.pop    (pop),
		.head   (head),
		.count  (fifo_cnt)
	);

	assign out_valid   = (fifo_cnt != '0);
	assign is_outline  = head.is_outline;
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign last_of_run = head.last;

	// queue never holds more than its depth
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= boe_pkg::FIFO_CW'(boe_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// a pixel in stage 1 always finds room for all of its results
	a_s1_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> ({1'b0, fifo_cnt} + (boe_pkg::FIFO_CW+1)'(boe_pkg::MAX_RES))
		             <= (boe_pkg::FIFO_CW+1)'(boe_pkg::FIFO_DEPTH))
		else $error("stage 1 without queue room");

	// stored column stays inside the line store
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < (CW+1)'(MAX_WIDTH))
		else $error("column position out of range");

endmodule

/* verif/binary_outline_extract_test.sv */
`timescale 1ns / 1ps

module binary_outline_extract_test;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	// cycles allowed for a pixel still in flight after the last expected beat
	localparam int DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// receiver hold-off, long enough to fill the result queue
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER_BEATS = 30;
	// pixels sent while neither side idles
	localparam int unsigned STEADY_FROM = 64;
	localparam int unsigned STEADY_TO   = 100;

	typedef enum logic {OP_CFG, OP_PIX} stim_op_t;

	// one row of the directed table: a register write or a pixel,
	// with an optional typed-in single result beat
	typedef struct packed {
		stim_op_t          op;
		logic              sel;
		logic [10:0]       val;
		logic [7:0]        px;
		logic              typed;
		boe_pkg::result_t  want;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_index = 1'b0;
	logic [10:0]                cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [7:0]                 pixel_value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       is_outline;
	logic [boe_pkg::POS_W-1:0]  out_row;
	logic [boe_pkg::POS_W-1:0]  out_col;
	logic                       last_of_run;

	binary_outline_extract uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_outline  (is_outline),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run)
	);

	always #4 clk = ~clk;

	// shadow of the block: two line stores, window, position and frame size
	bit          prev2_row [MAX_W];
	bit          prev1_row [MAX_W];
	bit [5:0]    win_cols;
	int unsigned next_col;
	int unsigned next_row;
	logic [10:0] frame_w = 11'd1024;
	logic [10:0] frame_h = 11'd1024;

	// beats decided by the last pixel, and beats still owed by the block
	boe_pkg::result_t  step_res [0:boe_pkg::MAX_RES-1];
	int                step_n;
	boe_pkg::result_t  outline_due [$];

	int unsigned cyc;
	int unsigned px_sent;
	bit          steady;
	int          errors;
	int          beats_done;
	int          hold_left;
	bit          held_once;
	stim_row_t   dir_tab [$];

	// size register as the block sees it: zero acts as one, overflow saturates
	function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned maxv);
		if (v == 11'd0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic void add_beat(input bit flag, input int unsigned r, input int unsigned c);
		boe_pkg::result_t b;
		b.is_outline = flag;
		b.row = r[boe_pkg::POS_W-1:0];
		b.col = c[boe_pkg::POS_W-1:0];
		b.last = 1'b0;
		step_res[step_n] = b;
		step_n++;
	endfunction

	// move the window one pixel and decide whatever that pixel completes
	function automatic void advance_window(input logic [7:0] v);
		int unsigned w;
		int unsigned h;
		bit fg;
		bit flag;
		bit top;
		bit mid;
		bit [2:0] col_now;
		w = clamp_size(frame_w, MAX_W);
		h = clamp_size(frame_h, MAX_H);
		fg = (v == 8'd0);
		step_n = 0;
		// position can lie beyond the frame after a size change
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h)
			next_row = 0;
		top = prev2_row[next_col];
		mid = prev1_row[next_col];
		col_now = {top, mid, fg};
		// upper-left neighbour now has its full 3x3 neighbourhood
		if (next_row >= 1 && next_col >= 1) begin
			if (!win_cols[1])
				flag = 1'b0;
			else if (next_row == 1 || next_col == 1 || next_col - 1 == w - 1)
				flag = 1'b1;
			else
				flag = !(win_cols == 6'h3f && col_now == 3'b111);
			add_beat(flag, next_row - 1, next_col - 1);
		end
		// last column of the row above is a border pixel
		if (next_row >= 1 && next_col == w - 1)
			add_beat(mid, next_row - 1, next_col);
		// last row pixels are decided on arrival
		if (next_row == h - 1)
			add_beat(fg, next_row, next_col);
		if (step_n > 0)
			step_res[step_n-1].last = 1'b1;
		prev2_row[next_col] = mid;
		prev1_row[next_col] = fg;
		win_cols = {win_cols[2:0], col_now};
		next_col++;
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
			if (next_row >= h)
				next_row = 0;
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic sel, input logic [10:0] val);
		stim_row_t s;
		s = '0;
		s.op = OP_CFG;
		s.sel = sel;
		s.val = val;
		return s;
	endfunction

	function automatic stim_row_t pix_row(input logic [7:0] v);
		stim_row_t s;
		s = '0;
		s.op = OP_PIX;
		s.px = v;
		return s;
	endfunction

	// pixel whose single beat is known without the shadow model
	function automatic stim_row_t pix_typed(input logic [7:0] v, input logic flag,
			input logic [boe_pkg::POS_W-1:0] r, input logic [boe_pkg::POS_W-1:0] c);
		stim_row_t s;
		s = pix_row(v);
		s.typed = 1'b1;
		s.want.is_outline = flag;
		s.want.row = r;
		s.want.col = c;
		s.want.last = 1'b1;
		return s;
	endfunction

	// cycle count, watchdog, and the stretch where neither side idles
	always @(posedge clk) begin
		cyc++;
		steady = (px_sent >= STEADY_FROM && px_sent < STEADY_TO);
		if (cyc >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall, one long hold-off while pixels keep coming
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held_once && beats_done >= HOLD_AFTER_BEATS) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 35);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// every result beat is matched against the oldest owed beat
	always @(posedge clk) begin
		boe_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outline_due.size() == 0) begin
				$error("unexpected beat: row %0d col %0d", out_row, out_col);
				errors++;
			end else begin
				want = outline_due.pop_front();
				check_field("is_outline", want.is_outline, is_outline);
				check_field("out_row", want.row, out_row);
				check_field("out_col", want.col, out_col);
				check_field("last_of_run", want.last, last_of_run);
				beats_done++;
			end
		end
	end

	// offer one pixel from a falling edge, return at the falling edge after acceptance
	task automatic send_pixel(input logic [7:0] v, input logic typed,
			input boe_pkg::result_t want);
		while (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_window(v);
		px_sent++;
		if (typed)
			outline_due.push_back(want);
		else
			for (int i = 0; i < step_n; i++)
				outline_due.push_back(step_res[i]);
		@(negedge clk);
	endtask

	// all owed beats in, then room for a pixel that decides nothing yet
	task automatic wait_idle;
		in_valid <= 1'b0;
		while (outline_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [10:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (sel == boe_pkg::CFG_WIDTH)
			frame_w = val;
		else
			frame_h = val;
	endtask

	// one frame of random content at the given size registers, at most max_px
	// pixels; a frame cut short is wrapped by the next size write
	task automatic run_frame(input logic [10:0] w_reg, input logic [10:0] h_reg,
			input int unsigned fg_pct, input int unsigned max_px,
			output int unsigned sent);
		logic [7:0] v;
		wait_idle();
		write_reg(boe_pkg::CFG_WIDTH, w_reg);
		write_reg(boe_pkg::CFG_HEIGHT, h_reg);
		sent = clamp_size(w_reg, MAX_W) * clamp_size(h_reg, MAX_H);
		if (sent > max_px)
			sent = max_px;
		for (int unsigned i = 0; i < sent; i++) begin
			if ($urandom_range(99) < fg_pct)
				v = 8'd0;
			else
				v = $urandom_range(1, 255);
			send_pixel(v, 1'b0, '0);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned rand_px;
		int unsigned fg_pct;
		logic [10:0] w_reg;
		logic [10:0] h_reg;

		// zero sizes act as a 1x1 frame: each pixel is its own border beat
		dir_tab.push_back(cfg_row(boe_pkg::CFG_WIDTH, 11'd0));
		dir_tab.push_back(cfg_row(boe_pkg::CFG_HEIGHT, 11'd0));
		dir_tab.push_back(pix_typed(8'h00, 1'b1, 10'd0, 10'd0));
		dir_tab.push_back(pix_typed(8'hff, 1'b0, 10'd0, 10'd0));
		dir_tab.push_back(pix_typed(8'h55, 1'b0, 10'd0, 10'd0));
		dir_tab.push_back(pix_typed(8'haa, 1'b0, 10'd0, 10'd0));
		// solid 3x3: center is foreground with no background neighbour
		dir_tab.push_back(cfg_row(boe_pkg::CFG_WIDTH, 11'd3));
		dir_tab.push_back(cfg_row(boe_pkg::CFG_HEIGHT, 11'd3));
		for (int i = 0; i < 9; i++)
			dir_tab.push_back(pix_row(8'h00));
		// 4 wide frame cut short: width shrinks mid-frame, position wraps
		// past the row and past the frame, then a full 2x3 frame follows
		dir_tab.push_back(cfg_row(boe_pkg::CFG_WIDTH, 11'd4));
		for (int i = 0; i < 10; i++)
			dir_tab.push_back(pix_row(i == 6 ? 8'h07 : 8'h00));
		dir_tab.push_back(cfg_row(boe_pkg::CFG_WIDTH, 11'd2));
		for (int i = 0; i < 6; i++)
			dir_tab.push_back(pix_row(i == 4 ? 8'h80 : 8'h00));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < dir_tab.size(); i++) begin
			if (dir_tab[i].op == OP_CFG) begin
				wait_idle();
				write_reg(dir_tab[i].sel, dir_tab[i].val);
			end else begin
				send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// size extremes, cut short: saturated width with zero height is one
		// long row, zero width with saturated height is one tall column
		run_frame(11'd2047, 11'd0, 70, 16, sent);
		run_frame(11'd0, 11'd2047, 70, 16, sent);

		// small random frames, density varying from mostly solid to sparse
		rand_px = 0;
		while (rand_px < 50) begin
			w_reg = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
			h_reg = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
			case ($urandom_range(2))
				0: fg_pct = 85;
				1: fg_pct = 50;
				default: fg_pct = 15;
			endcase
			run_frame(w_reg, h_reg, fg_pct, 100, sent);
			rand_px += sent;
		end

		in_valid <= 1'b0;
		while (outline_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
